### rtl/hdcf_pkg.sv
package hdcf_pkg;

  localparam int FRAC_BITS = 16;

  // square root unit: 64-bit radicand, one root bit per stage
  localparam int ISQ_W  = 64;
  localparam int ISQ_RW = ISQ_W / 2;

  // slip direction divider: quotient magnitude up to 1.0
  localparam int DIV_STAGES = FRAC_BITS + 1;
  localparam int DIV_NW     = 32 + FRAC_BITS;
  localparam int S_W        = FRAC_BITS + 2;
  localparam int ONE        = 1 << FRAC_BITS;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NORMAL_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_STIFFNESS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHEAR_DAMPING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION_COEFF   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd5;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [17:0] z;
  } nvec_t;

  typedef struct packed {
    logic signed [S_W-1:0] x;
    logic signed [S_W-1:0] y;
    logic signed [S_W-1:0] z;
  } svec_t;

  typedef struct packed {
    logic [30:0] overlap;
    vec_t        arm;
    vec_t        dv;
    nvec_t       n;
  } ctx_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [65:0] term(input logic signed [63:0] p);
    return 66'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
    return sat32(term(p));
  endfunction

  function automatic logic [30:0] usat64(input logic [63:0] u);
    if (u > 64'h7FFFFFFF) return '1;
    return u[30:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

### rtl/hertz_damped_contact_force_core.sv
// Path from item acceptance to result valid: two 32-stage square-root pipelines in series,
// then the 17-stage slip-direction divider and the force stages.
// Throughput: one item per cycle; a stalled output holds the whole pipeline in place.
// Reset: synchronous; clears all stage valid bits and sets every coefficient to zero.
module hertz_damped_contact_force_core
  import hdcf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [30:0]          wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [30:0]          overlap,
  input  logic signed [31:0]   arm_x,
  input  logic signed [31:0]   arm_y,
  input  logic signed [31:0]   arm_z,
  input  logic signed [31:0]   rel_vel_x,
  input  logic signed [31:0]   rel_vel_y,
  input  logic signed [31:0]   rel_vel_z,
  input  logic signed [17:0]   normal_x,
  input  logic signed [17:0]   normal_y,
  input  logic signed [17:0]   normal_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   force_x,
  output logic signed [31:0]   force_y,
  output logic signed [31:0]   force_z,
  output logic signed [31:0]   moment_x,
  output logic signed [31:0]   moment_y,
  output logic signed [31:0]   moment_z
);

  localparam int T_DN       = 2;
  localparam int T_ROOT     = ISQ_RW;
  localparam int T_P15      = T_ROOT + 1;
  localparam int T_KP       = T_ROOT + 2;
  localparam int T_FN       = T_ROOT + 3;
  localparam int T_NR       = T_ROOT + 4;
  localparam int T_E        = T_ROOT + 5;
  localparam int T_SQ       = T_ROOT + 6;
  localparam int T_SUM      = T_ROOT + 7;
  localparam int T_MAG      = T_SUM + ISQ_RW;
  localparam int T_DS_RAW   = T_MAG + 1;
  localparam int T_DS       = T_MAG + 2;
  localparam int T_KSDS_RAW = T_MAG + 3;
  localparam int T_KSDS     = T_MAG + 4;
  localparam int T_S        = T_MAG + DIV_STAGES;
  localparam int T_DVS_RAW  = T_S + 1;
  localparam int T_DVS      = T_S + 2;
  localparam int T_VS_RAW   = T_S + 3;
  localparam int T_FT1      = T_S + 4;
  localparam int T_FTS      = T_S + 5;
  localparam int T_FT_RAW   = T_S + 6;
  localparam int T_FT       = T_S + 7;
  localparam int T_X_RAW    = T_S + 8;
  localparam int T_OUT      = T_S + 9;

  logic [30:0] kn, vn, ks, vs, mu, dt;

  logic             en;
  logic [T_OUT:1]   vld;
  ctx_t             ctx_in;
  ctx_t             ctx_q [1:T_FT];

  logic signed [63:0] dnp_x, dnp_y, dnp_z;
  logic signed [31:0] dn_q [T_DN:T_FN];
  logic [ISQ_RW-1:0]  root_ovl;
  logic [63:0]        p15raw;
  logic signed [63:0] kp_raw, vd_raw;
  logic signed [31:0] fn_q;
  logic signed [63:0] fnvraw_x, fnvraw_y, fnvraw_z;
  logic signed [63:0] qnraw_x, qnraw_y, qnraw_z;
  vec_t               fnv_q [T_E:T_X_RAW];
  vec_t               e_q   [T_E:T_MAG];
  logic [63:0]        sqe_x, sqe_y, sqe_z, sqf_x, sqf_y, sqf_z;
  logic [63:0]        mag2, f2;
  logic [ISQ_RW-1:0]  mag, fmag;
  logic               mnz_q [T_DS_RAW:T_FT];
  logic [63:0]        dsraw, ft2raw, ksraw;
  logic [30:0]        ds_q;
  logic [30:0]        ft2_q  [T_DS:T_FT1];
  logic [30:0]        ksds_q [T_KSDS:T_VS_RAW];
  svec_t              s;
  svec_t              s_q [T_S+1:T_FTS];
  logic signed [63:0] dvsraw_x, dvsraw_y, dvsraw_z;
  logic signed [31:0] dvs_q;
  logic signed [63:0] vsraw;
  logic signed [31:0] ft1_q, fts_q, ft2s;
  logic signed [63:0] ftraw_x, ftraw_y, ftraw_z;
  vec_t               ft_q [T_FT:T_X_RAW];
  logic signed [63:0] mx_a, mx_b, my_a, my_b, mz_a, mz_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      kn <= '0;
      vn <= '0;
      ks <= '0;
      vs <= '0;
      mu <= '0;
      dt <= '0;
    end else if (wr_en) begin
      case (wr_index)
        REG_NORMAL_STIFFNESS: kn <= wr_data;
        REG_NORMAL_DAMPING:   vn <= wr_data;
        REG_SHEAR_STIFFNESS:  ks <= wr_data;
        REG_SHEAR_DAMPING:    vs <= wr_data;
        REG_FRICTION_COEFF:   mu <= wr_data;
        REG_TIME_STEP:        dt <= wr_data;
        default: ;
      endcase
    end
  end

  assign en        = !vld[T_OUT] || out_ready;
  assign in_ready  = en && !rst;
  assign out_valid = vld[T_OUT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-1:1], in_valid};
    end
  end

  always_comb begin
    ctx_in.overlap = overlap;
    ctx_in.arm.x   = arm_x;
    ctx_in.arm.y   = arm_y;
    ctx_in.arm.z   = arm_z;
    ctx_in.dv.x    = rel_vel_x;
    ctx_in.dv.y    = rel_vel_y;
    ctx_in.dv.z    = rel_vel_z;
    ctx_in.n.x     = normal_x;
    ctx_in.n.y     = normal_y;
    ctx_in.n.z     = normal_z;
  end

  hdcf_isqrt u_root_ovl (
    .clk  (clk),
    .en   (en),
    .x    (ISQ_W'(overlap) << FRAC_BITS),
    .root (root_ovl)
  );

  hdcf_isqrt u_root_slip (
    .clk  (clk),
    .en   (en),
    .x    (mag2),
    .root (mag)
  );

  hdcf_isqrt u_root_fn (
    .clk  (clk),
    .en   (en),
    .x    (f2),
    .root (fmag)
  );

  hdcf_div u_div_x (.clk(clk), .en(en), .e(e_q[T_MAG].x), .mag(mag), .s(s.x));
  hdcf_div u_div_y (.clk(clk), .en(en), .e(e_q[T_MAG].y), .mag(mag), .s(s.y));
  hdcf_div u_div_z (.clk(clk), .en(en), .e(e_q[T_MAG].z), .mag(mag), .s(s.z));

  assign ft2s = $signed({1'b0, ft2_q[T_FT1]});

  always_ff @(posedge clk) begin
    if (en) begin
      ctx_q[1] <= ctx_in;
      for (int i = 2; i <= T_FT; i++) ctx_q[i] <= ctx_q[i-1];

      // dv.n
      dnp_x <= ctx_in.dv.x * ctx_in.n.x;
      dnp_y <= ctx_in.dv.y * ctx_in.n.y;
      dnp_z <= ctx_in.dv.z * ctx_in.n.z;
      dn_q[T_DN] <= sat32(term(dnp_x) + term(dnp_y) + term(dnp_z));
      for (int i = T_DN + 1; i <= T_FN; i++) dn_q[i] <= dn_q[i-1];

      // normal force magnitude
      p15raw <= 64'(ctx_q[T_ROOT].overlap) * 64'(root_ovl);
      kp_raw <= $signed({1'b0, kn}) * $signed({1'b0, usat64(p15raw >> FRAC_BITS)});
      vd_raw <= $signed({1'b0, vn}) * dn_q[T_P15];
      fn_q   <= sat32(66'(qsat(vd_raw)) - 66'(qsat(kp_raw)));

      fnvraw_x <= fn_q * ctx_q[T_FN].n.x;
      fnvraw_y <= fn_q * ctx_q[T_FN].n.y;
      fnvraw_z <= fn_q * ctx_q[T_FN].n.z;
      qnraw_x  <= dn_q[T_FN] * ctx_q[T_FN].n.x;
      qnraw_y  <= dn_q[T_FN] * ctx_q[T_FN].n.y;
      qnraw_z  <= dn_q[T_FN] * ctx_q[T_FN].n.z;

      fnv_q[T_E].x <= qsat(fnvraw_x);
      fnv_q[T_E].y <= qsat(fnvraw_y);
      fnv_q[T_E].z <= qsat(fnvraw_z);
      for (int i = T_E + 1; i <= T_X_RAW; i++) fnv_q[i] <= fnv_q[i-1];

      // slip vector
      e_q[T_E].x <= sat32(66'(ctx_q[T_NR].dv.x) - 66'(qsat(qnraw_x)));
      e_q[T_E].y <= sat32(66'(ctx_q[T_NR].dv.y) - 66'(qsat(qnraw_y)));
      e_q[T_E].z <= sat32(66'(ctx_q[T_NR].dv.z) - 66'(qsat(qnraw_z)));
      for (int i = T_E + 1; i <= T_MAG; i++) e_q[i] <= e_q[i-1];

      sqe_x <= 64'(abs32(e_q[T_E].x)) * 64'(abs32(e_q[T_E].x));
      sqe_y <= 64'(abs32(e_q[T_E].y)) * 64'(abs32(e_q[T_E].y));
      sqe_z <= 64'(abs32(e_q[T_E].z)) * 64'(abs32(e_q[T_E].z));
      sqf_x <= 64'(abs32(fnv_q[T_E].x)) * 64'(abs32(fnv_q[T_E].x));
      sqf_y <= 64'(abs32(fnv_q[T_E].y)) * 64'(abs32(fnv_q[T_E].y));
      sqf_z <= 64'(abs32(fnv_q[T_E].z)) * 64'(abs32(fnv_q[T_E].z));
      mag2  <= sqe_x + sqe_y + sqe_z;
      f2    <= sqf_x + sqf_y + sqf_z;

      // slip displacement and friction cap
      mnz_q[T_DS_RAW] <= (mag != '0);
      for (int i = T_DS_RAW + 1; i <= T_FT; i++) mnz_q[i] <= mnz_q[i-1];
      dsraw  <= 64'(usat64(64'(mag))) * 64'(dt);
      ft2raw <= 64'(usat64(64'(fmag))) * 64'(mu);
      ds_q   <= usat64(dsraw >> FRAC_BITS);
      ft2_q[T_DS] <= usat64(ft2raw >> FRAC_BITS);
      for (int i = T_DS + 1; i <= T_FT1; i++) ft2_q[i] <= ft2_q[i-1];
      ksraw  <= 64'(ks) * 64'(ds_q);
      ksds_q[T_KSDS] <= usat64(ksraw >> FRAC_BITS);
      for (int i = T_KSDS + 1; i <= T_VS_RAW; i++) ksds_q[i] <= ksds_q[i-1];

      // shear magnitude
      s_q[T_S+1] <= s;
      for (int i = T_S + 2; i <= T_FTS; i++) s_q[i] <= s_q[i-1];
      dvsraw_x <= ctx_q[T_S].dv.x * s.x;
      dvsraw_y <= ctx_q[T_S].dv.y * s.y;
      dvsraw_z <= ctx_q[T_S].dv.z * s.z;
      dvs_q    <= sat32(term(dvsraw_x) + term(dvsraw_y) + term(dvsraw_z));
      vsraw    <= $signed({1'b0, vs}) * dvs_q;
      ft1_q    <= sat32(66'($signed({1'b0, ksds_q[T_VS_RAW]})) + 66'(qsat(vsraw)));
      fts_q    <= (ft1_q < ft2s) ? ft1_q : ft2s;

      ftraw_x <= fts_q * s_q[T_FTS].x;
      ftraw_y <= fts_q * s_q[T_FTS].y;
      ftraw_z <= fts_q * s_q[T_FTS].z;
      // zero slip: no shear force
      ft_q[T_FT].x <= mnz_q[T_FT_RAW] ? qsat(ftraw_x) : '0;
      ft_q[T_FT].y <= mnz_q[T_FT_RAW] ? qsat(ftraw_y) : '0;
      ft_q[T_FT].z <= mnz_q[T_FT_RAW] ? qsat(ftraw_z) : '0;
      for (int i = T_FT + 1; i <= T_X_RAW; i++) ft_q[i] <= ft_q[i-1];

      // arm x shear force
      mx_a <= ctx_q[T_FT].arm.y * ft_q[T_FT].z;
      mx_b <= ctx_q[T_FT].arm.z * ft_q[T_FT].y;
      my_a <= ctx_q[T_FT].arm.z * ft_q[T_FT].x;
      my_b <= ctx_q[T_FT].arm.x * ft_q[T_FT].z;
      mz_a <= ctx_q[T_FT].arm.x * ft_q[T_FT].y;
      mz_b <= ctx_q[T_FT].arm.y * ft_q[T_FT].x;

      moment_x <= sat32(term(mx_a) - term(mx_b));
      moment_y <= sat32(term(my_a) - term(my_b));
      moment_z <= sat32(term(mz_a) - term(mz_b));
      force_x  <= sat32(66'(fnv_q[T_X_RAW].x) + 66'(ft_q[T_X_RAW].x));
      force_y  <= sat32(66'(fnv_q[T_X_RAW].y) + 66'(ft_q[T_X_RAW].y));
      force_z  <= sat32(66'(fnv_q[T_X_RAW].z) + 66'(ft_q[T_X_RAW].z));
    end
  end

`ifndef SYNTHESIS
  a_stall_holds_valid: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved during a stall");

  a_last_stage_moves: assert property (@(posedge clk) disable iff (rst)
    en && vld[T_OUT-1] |=> out_valid)
    else $error("item lost before the output register");

  a_dir_bounded: assert property (@(posedge clk) disable iff (rst)
    vld[T_S] && mnz_q[T_S] |->
      (s.x <= ONE) && (s.x >= -ONE) && (s.y <= ONE) && (s.y >= -ONE) &&
      (s.z <= ONE) && (s.z >= -ONE))
    else $error("slip direction component beyond unit length");

  a_no_shear_without_slip: assert property (@(posedge clk) disable iff (rst)
    vld[T_FT] && !mnz_q[T_FT] |-> (ft_q[T_FT] == '0))
    else $error("shear force present with zero slip");
`endif

endmodule

### rtl/hdcf_isqrt.sv
module hdcf_isqrt
  import hdcf_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [ISQ_W-1:0]  x,
  output logic [ISQ_RW-1:0] root
);

  logic [ISQ_W-1:0]  rem  [1:ISQ_RW];
  logic [ISQ_RW-1:0] part [1:ISQ_RW];

  for (genvar g = 0; g < ISQ_RW; g++) begin : g_stage
    localparam int K = ISQ_RW - 1 - g;
    logic [ISQ_W-1:0]  rin;
    logic [ISQ_W-1:0]  trial;
    logic [ISQ_RW-1:0] qin;

    if (g == 0) begin : g_first
      assign rin = x;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem[g];
      assign qin = part[g];
    end

    assign trial = (ISQ_W'(qin) << (K + 1)) + (ISQ_W'(1) << (2 * K));

    always_ff @(posedge clk) begin
      if (en) begin
        if (rin >= trial) begin
          rem[g+1]  <= rin - trial;
          part[g+1] <= qin | (ISQ_RW'(1) << K);
        end else begin
          rem[g+1]  <= rin;
          part[g+1] <= qin;
        end
      end
    end
  end

  assign root = part[ISQ_RW];

endmodule

### rtl/hdcf_div.sv
module hdcf_div
  import hdcf_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [31:0]    e,
  input  logic [31:0]           mag,
  output logic signed [S_W-1:0] s
);

  logic [DIV_NW-1:0]     rem [1:DIV_STAGES];
  logic [DIV_STAGES-1:0] quo [1:DIV_STAGES];
  logic [31:0]           dd  [1:DIV_STAGES];
  logic                  neg [1:DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    localparam int K = DIV_STAGES - 1 - g;
    logic [DIV_NW-1:0]     rin;
    logic [DIV_NW-1:0]     trial;
    logic [DIV_STAGES-1:0] qin;
    logic [31:0]           din;
    logic                  nin;

    if (g == 0) begin : g_first
      assign rin = DIV_NW'(abs32(e)) << FRAC_BITS;
      assign qin = '0;
      assign din = mag;
      assign nin = e[31];
    end else begin : g_next
      assign rin = rem[g];
      assign qin = quo[g];
      assign din = dd[g];
      assign nin = neg[g];
    end

    assign trial = DIV_NW'(din) << K;

    always_ff @(posedge clk) begin
      if (en) begin
        dd[g+1]  <= din;
        neg[g+1] <= nin;
        if (rin >= trial) begin
          rem[g+1] <= rin - trial;
          quo[g+1] <= qin | (DIV_STAGES'(1) << K);
        end else begin
          rem[g+1] <= rin;
          quo[g+1] <= qin;
        end
      end
    end
  end

  // truncation toward zero: sign applied to the magnitude quotient
  assign s = neg[DIV_STAGES] ? -$signed({1'b0, quo[DIV_STAGES]})
                             :  $signed({1'b0, quo[DIV_STAGES]});

endmodule
